@@ hw/rtl/tsm_pkg.sv @@
// Shared types and constants for the timer slot manager.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package tsm_pkg;

  // Number of timer slots (1 to 16).
  localparam int TIMER_COUNT = 16;
  localparam int SLOT_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

  // Command codes.
  localparam logic [2:0] CMD_CREATE    = 3'd0;
  localparam logic [2:0] CMD_DESTROY   = 3'd1;
  localparam logic [2:0] CMD_START     = 3'd2;
  localparam logic [2:0] CMD_STOP      = 3'd3;
  localparam logic [2:0] CMD_STATUS    = 3'd4;
  localparam logic [2:0] CMD_CONFIGURE = 3'd5;

  // Status codes.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_PERIOD = 2'd1;
  localparam logic [1:0] ST_NO_SLOT    = 2'd2;
  localparam logic [1:0] ST_BAD_SLOT   = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] slot_sel;
    logic [31:0] period_val;
    logic        periodic;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  new_slot;
    logic        running;
    logic [31:0] elapsed_val;
  } rsp_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] idx;
  } free_t;

endpackage

`default_nettype wire

@@ hw/rtl/timer_slot_manager_top.sv @@
// Top level of the timer slot manager: stream ports, input and result
// registers around the slot table. Depends on tsm_pkg and tsm_slot_table.
`default_nettype none

// The block keeps a table of TIMER_COUNT software timers and answers each
// command transaction with exactly one response transaction, in order. A
// command is captured in an input register; from there it is decoded
// against the slot table, the table is updated and the response is loaded
// into the output register once that register is empty or being drained. The
// block therefore sustains one transaction per clock cycle while out_tready
// stays high; each response passes the input and output registers. The
// only limit is the single pass through the slot table, which reads one
// addressed slot and searches the in-use bitmap for the lowest free entry.
// When the response is not taken, the input register still holds one further
// command, after which in_tready drops. Reset clears the in-use, running and
// periodic bits of every slot at once, so no initialization pass is needed;
// the period and elapsed counts of a slot are written by create before use.
module timer_slot_manager_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Command channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [71:0] in_tdata,   // slot_sel[31:0], period_val[63:32],
                                       // periodic[64], zero fill [71:65]
  input  wire logic [2:0]  in_tuser,   // cmd[2:0]
  // Response channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // status[1:0], new_slot[5:2],
                                       // running[6], elapsed_val[38:7],
                                       // zero fill [39]
);
  import tsm_pkg::*;

  logic s1_valid_r;
  cmd_t s1_cmd_r;
  logic out_valid_r;
  rsp_t out_rsp_r;
  rsp_t rsp;
  logic advance;
  logic exec;

  // The output register can take a new response when it is empty or being
  // drained this cycle; the input register refills whenever it moves on.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign exec      = s1_valid_r && advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_cmd_r.cmd        <= in_tuser;
      s1_cmd_r.slot_sel   <= in_tdata[31:0];
      s1_cmd_r.period_val <= in_tdata[63:32];
      s1_cmd_r.periodic   <= in_tdata[64];
    end
    if (exec) begin
      out_rsp_r <= rsp;
    end
  end

  tsm_slot_table u_slot_table (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (exec),
    .cmd   (s1_cmd_r),
    .rsp   (rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_rsp_r.elapsed_val, out_rsp_r.running,
                       out_rsp_r.new_slot, out_rsp_r.status};

  // A stalled input side means a command is held behind a stalled response.
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_tvalid && !out_tready))
    else $error("in_tready low without a held command and a stalled response");

  // A failed command carries no slot, running bit or count.
  a_fail_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_rsp_r.status != ST_OK) |->
      (out_rsp_r.new_slot == 4'd0 && !out_rsp_r.running &&
       out_rsp_r.elapsed_val == 32'd0))
    else $error("failed response carries nonzero result fields");

  // A new response only follows a command held in the input register.
  a_rsp_source : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid_r))
    else $error("response produced without a pending command");

  // A periodic reload reports zero elapsed time while still running.
  a_reload_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_rsp_r.running) |->
      (out_rsp_r.status == ST_OK && out_rsp_r.elapsed_val == 32'd0))
    else $error("running response without ok status and zero elapsed count");

endmodule

`default_nettype wire

@@ hw/rtl/tsm_find_free.sv @@
// Lowest-free-slot search over the in-use bitmap.
// Depends on tsm_pkg.
`default_nettype none

module tsm_find_free (
  input  wire logic [tsm_pkg::TIMER_COUNT-1:0] in_use,
  output tsm_pkg::free_t                        free
);
  import tsm_pkg::*;

  // Scan from the top down so the lowest free slot wins.
  always_comb begin
    free = '0;
    for (int i = TIMER_COUNT - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free.found = 1'b1;
        free.idx   = SLOT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tsm_slot_table.sv @@
// Timer slot table: per-slot state registers and the command decode that
// updates them and forms the response. Depends on tsm_pkg and tsm_find_free.
`default_nettype none

module tsm_slot_table (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           exec,
  input  wire tsm_pkg::cmd_t  cmd,
  output tsm_pkg::rsp_t       rsp
);
  import tsm_pkg::*;

  logic [TIMER_COUNT-1:0] in_use_r;
  logic [TIMER_COUNT-1:0] running_r;
  logic [TIMER_COUNT-1:0] periodic_r;
  logic [31:0]            period_r  [TIMER_COUNT];
  logic [31:0]            elapsed_r [TIMER_COUNT];

  free_t             free;
  logic [SLOT_W-1:0] idx;
  logic              id_ok;
  logic              period_zero;
  logic [31:0]       sum;

  // Decoded updates.
  logic              we_create;
  logic              we_destroy;
  logic              we_run;
  logic              run_nxt;
  logic              we_elapsed;
  logic [31:0]       elapsed_nxt;
  logic              we_period;

  tsm_find_free u_find_free (
    .in_use (in_use_r),
    .free   (free)
  );

  assign idx         = cmd.slot_sel[SLOT_W-1:0];
  assign id_ok       = (cmd.slot_sel < 32'(TIMER_COUNT)) && in_use_r[idx];
  assign period_zero = (cmd.period_val == 32'd0);
  assign sum         = elapsed_r[idx] + period_r[idx];

  always_comb begin
    rsp         = '0;
    we_create   = 1'b0;
    we_destroy  = 1'b0;
    we_run      = 1'b0;
    run_nxt     = 1'b0;
    we_elapsed  = 1'b0;
    elapsed_nxt = '0;
    we_period   = 1'b0;
    unique case (cmd.cmd) inside
      CMD_CREATE: begin
        if (period_zero) begin
          rsp.status = ST_BAD_PERIOD;
        end else if (!free.found) begin
          rsp.status = ST_NO_SLOT;
        end else begin
          rsp.status   = ST_OK;
          rsp.new_slot = 4'(free.idx);
          we_create    = 1'b1;
        end
      end
      CMD_DESTROY, CMD_START, CMD_STOP, CMD_STATUS, CMD_CONFIGURE: begin
        if (!id_ok) begin
          rsp.status = ST_BAD_SLOT;
        end else begin
          rsp.status = ST_OK;
          unique case (cmd.cmd)
            CMD_DESTROY: begin
              we_destroy = 1'b1;
            end
            CMD_START: begin
              we_run      = 1'b1;
              run_nxt     = 1'b1;
              we_elapsed  = 1'b1;
              elapsed_nxt = '0;
            end
            CMD_STOP: begin
              we_run  = 1'b1;
              run_nxt = 1'b0;
            end
            CMD_STATUS: begin
              if (running_r[idx]) begin
                // A periodic timer reloads, a one-shot timer expires.
                we_elapsed  = 1'b1;
                elapsed_nxt = periodic_r[idx] ? 32'd0 : sum;
                we_run      = 1'b1;
                run_nxt     = periodic_r[idx];
                rsp.running     = periodic_r[idx];
                rsp.elapsed_val = periodic_r[idx] ? 32'd0 : sum;
              end else begin
                rsp.running     = 1'b0;
                rsp.elapsed_val = elapsed_r[idx];
              end
            end
            default: begin
              // Configure: the slot check comes before the period check.
              if (period_zero) begin
                rsp.status = ST_BAD_PERIOD;
              end else begin
                we_period = 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        rsp = '0;
      end
    endcase
  end

  // Control bits, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r   <= '0;
      running_r  <= '0;
      periodic_r <= '0;
    end else if (exec) begin
      if (we_create) begin
        in_use_r[free.idx]   <= 1'b1;
        running_r[free.idx]  <= 1'b0;
        periodic_r[free.idx] <= cmd.periodic;
      end
      if (we_destroy) begin
        in_use_r[idx]  <= 1'b0;
        running_r[idx] <= 1'b0;
      end
      if (we_run) begin
        running_r[idx] <= run_nxt;
      end
    end
  end

  // Period and elapsed counts; a slot is always written by create before use.
  always_ff @(posedge clk) begin
    if (exec) begin
      if (we_create) begin
        period_r[free.idx]  <= cmd.period_val;
        elapsed_r[free.idx] <= '0;
      end
      if (we_elapsed) begin
        elapsed_r[idx] <= elapsed_nxt;
      end
      if (we_period) begin
        period_r[idx] <= cmd.period_val;
      end
    end
  end

endmodule

`default_nettype wire

@@ tb/tsm_response_checker.sv @@
// Response checker for the timer slot manager: watches both stream channels,
// predicts every response from its own copy of the slot table and compares.
// Depends on tsm_pkg for command codes, status codes and the slot count.
`default_nettype none

module tsm_response_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [71:0] in_tdata,
  input  wire logic [2:0]  in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  output int               fail_count,
  output int               pending,
  output int               cmds_seen,
  output int               rsps_checked,
  output int               n_ok,
  output int               n_bad_period,
  output int               n_no_slot,
  output int               n_bad_slot
);
  import tsm_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the slot table.
  logic        tbl_in_use   [TIMER_COUNT];
  logic        tbl_running  [TIMER_COUNT];
  logic        tbl_periodic [TIMER_COUNT];
  logic [31:0] tbl_period   [TIMER_COUNT];
  logic [31:0] tbl_elapsed  [TIMER_COUNT];

  rsp_t expected_rsp [$];

  // Applies one command to the shadow table and returns the response it earns.
  function automatic rsp_t predict_response(input logic [2:0] cmd, input logic [31:0] id,
                                            input logic [31:0] period, input logic periodic);
    rsp_t r;
    logic found;
    logic live;
    int   i;
    r     = '0;
    found = 1'b0;
    live  = (id < TIMER_COUNT) ? tbl_in_use[id] : 1'b0;
    case (cmd)
      CMD_CREATE: begin
        if (period == '0) begin
          r.status = ST_BAD_PERIOD;
        end else begin
          r.status = ST_NO_SLOT;
          for (i = 0; i < TIMER_COUNT; i++) begin
            if (!found && !tbl_in_use[i]) begin
              found           = 1'b1;
              tbl_in_use[i]   = 1'b1;
              tbl_running[i]  = 1'b0;
              tbl_period[i]   = period;
              tbl_periodic[i] = periodic;
              tbl_elapsed[i]  = '0;
              r.status        = ST_OK;
              r.new_slot      = i[3:0];
            end
          end
        end
      end
      CMD_DESTROY, CMD_START, CMD_STOP, CMD_STATUS, CMD_CONFIGURE: begin
        if (!live) begin
          r.status = ST_BAD_SLOT;
        end else begin
          case (cmd)
            CMD_DESTROY: begin
              tbl_running[id] = 1'b0;
              tbl_in_use[id]  = 1'b0;
            end
            CMD_START: begin
              tbl_running[id] = 1'b1;
              tbl_elapsed[id] = '0;
            end
            CMD_STOP: tbl_running[id] = 1'b0;
            CMD_STATUS: begin
              if (tbl_running[id]) begin
                tbl_elapsed[id] = tbl_elapsed[id] + tbl_period[id];
                if (tbl_periodic[id]) tbl_elapsed[id] = '0;
                else tbl_running[id] = 1'b0;
              end
              r.running     = tbl_running[id];
              r.elapsed_val = tbl_elapsed[id];
            end
            default: begin
              if (period == '0) r.status = ST_BAD_PERIOD;
              else tbl_period[id] = period;
            end
          endcase
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst_n) begin
      for (int i = 0; i < TIMER_COUNT; i++) begin
        tbl_in_use[i]   = 1'b0;
        tbl_running[i]  = 1'b0;
        tbl_periodic[i] = 1'b0;
        tbl_period[i]   = '0;
        tbl_elapsed[i]  = '0;
      end
      expected_rsp.delete();
      fail_count   = 0;
      cmds_seen    = 0;
      rsps_checked = 0;
      n_ok         = 0;
      n_bad_period = 0;
      n_no_slot    = 0;
      n_bad_slot   = 0;
    end else begin
      // Responses first: one accepted in this cycle can never belong to the
      // command accepted at the same edge.
      if (out_tvalid && out_tready) begin
        got.status      = out_tdata[1:0];
        got.new_slot    = out_tdata[5:2];
        got.running     = out_tdata[6];
        got.elapsed_val = out_tdata[38:7];
        if (expected_rsp.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("[%0t] Unexpected response: status %0d slot %0d running %0b elapsed %0h",
                     $time, got.status, got.new_slot, got.running, got.elapsed_val);
          fail_count++;
        end else begin
          want = expected_rsp.pop_front();
          if (got.status !== want.status || got.new_slot !== want.new_slot ||
              got.running !== want.running || got.elapsed_val !== want.elapsed_val) begin
            if (fail_count < REPORT_LIMIT) begin
              $write("[%0t] Response %0d mismatch: status %0d/%0d slot %0d/%0d ",
                     $time, rsps_checked, want.status, got.status, want.new_slot,
                     got.new_slot);
              $display("running %0b/%0b elapsed %0h/%0h (expected/actual)",
                       want.running, got.running, want.elapsed_val, got.elapsed_val);
            end
            fail_count++;
          end
          rsps_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_response(in_tuser, in_tdata[31:0], in_tdata[63:32], in_tdata[64]);
        case (want.status)
          ST_OK:         n_ok++;
          ST_BAD_PERIOD: n_bad_period++;
          ST_NO_SLOT:    n_no_slot++;
          default:       n_bad_slot++;
        endcase
        expected_rsp.push_back(want);
        cmds_seen++;
      end
    end
    pending = expected_rsp.size();
  end

endmodule

`default_nettype wire

@@ tb/tb_timer_slot_manager_top.sv @@
// Testbench top for the timer slot manager: clock, reset, command stimulus,
// random backpressure, watchdog and verdict. Depends on tsm_pkg,
// timer_slot_manager_top and tsm_response_checker.
`default_nettype none

module tb_timer_slot_manager_top;
  import tsm_pkg::*;

  // The two command codes the block does not define. They must be answered
  // with an all-zero ok response and must leave the table untouched.
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int WATCHDOG_LIMIT = 2000;
  // A short drain at the end catches any response that should not be there.
  localparam int DRAIN_CYCLES   = 10;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // slot_sel[31:0], period_val[63:32], periodic[64], zero [71:65]
  logic [2:0]  in_tuser;   // cmd[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // status[1:0], new_slot[5:2], running[6], elapsed_val[38:7], zero [39]

  int fail_count;
  int pending;
  int cmds_seen;
  int rsps_checked;
  int n_ok;
  int n_bad_period;
  int n_no_slot;
  int n_bad_slot;

  int idle_cycles;
  int burst_left;

  timer_slot_manager_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  tsm_response_checker checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .cmds_seen    (cmds_seen),
    .rsps_checked (rsps_checked),
    .n_ok         (n_ok),
    .n_bad_period (n_bad_period),
    .n_no_slot    (n_no_slot),
    .n_bad_slot   (n_bad_slot)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle lengths for both channels: mostly none or a few cycles, now and then
  // a long pause so that the block sees both full and empty pipelines.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // Sends one command transaction. It is entered and left at a falling edge.
  // The valid signal is only dropped when a gap is actually inserted, so back
  // to back transactions keep in_tvalid high without a glitch in between.
  task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] id,
                          input logic [31:0] period, input logic periodic);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = pick_gap();
      if ($urandom_range(0, 99) < 3) burst_left = $urandom_range(30, 80);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, periodic, period, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Builds one random command. Slot numbers mostly stay inside the table so
  // that commands actually land on live timers; the rest probe the range check
  // just past the table and across the whole 32-bit field. The destroy weight
  // swings with the phase so the table alternately fills up and drains.
  task automatic send_random_cmd(input bit drain_phase);
    int          r;
    int          create_w;
    int          destroy_w;
    logic [2:0]  cmd;
    logic [31:0] id;
    logic [31:0] period;
    create_w  = drain_phase ? 15 : 25;
    destroy_w = drain_phase ? 25 : 8;
    r = $urandom_range(0, 99);
    if (r < create_w) cmd = CMD_CREATE;
    else if (r < create_w + destroy_w) cmd = CMD_DESTROY;
    else if (r < 55) cmd = CMD_START;
    else if (r < 64) cmd = CMD_STOP;
    else if (r < 85) cmd = CMD_STATUS;
    else if (r < 97) cmd = CMD_CONFIGURE;
    else cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));

    r = $urandom_range(0, 99);
    if (r < 85) id = $urandom_range(0, TIMER_COUNT - 1);
    else if (r < 92) id = $urandom_range(TIMER_COUNT, TIMER_COUNT + 3);
    else id = $urandom();

    r = $urandom_range(0, 99);
    if (r < 6) period = '0;
    else if (r < 12) period = '1;
    else if (r < 40) period = $urandom_range(1, 1000);
    else period = $urandom();

    send_cmd(cmd, id, period, 1'($urandom_range(0, 1)));
  endtask

  // The result side holds off at random. Some hold periods are long so that
  // there are stretches in which the block runs at full rate.
  initial begin
    int stall;
    int hold;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = pick_gap();
      hold  = ($urandom_range(0, 99) < 15) ? $urandom_range(30, 120) : $urandom_range(1, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      repeat (hold) @(negedge clk);
    end
  end

  // A stretch of cycles longer than WATCHDOG_LIMIT without a single accepted
  // transaction on either channel means the block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] Watchdog expired with %0d responses outstanding.", $time, pending);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Addressing a free slot is rejected, as is a zero period.
    send_cmd(CMD_STATUS, 32'd0, 32'd0, 1'b0);
    send_cmd(CMD_CREATE, 32'd0, 32'd0, 1'b1);
    // Largest period as a one-shot timer in slot 0, smallest as a periodic
    // timer in slot 1.
    send_cmd(CMD_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_cmd(CMD_CREATE, 32'hFFFF_FFFF, 32'd1, 1'b1);
    // A stopped timer reports its stored values unchanged.
    send_cmd(CMD_STATUS, 32'd0, 32'd0, 1'b1);
    // A one-shot timer advances by its full period once and then stops.
    send_cmd(CMD_START, 32'd0, 32'd0, 1'b0);
    send_cmd(CMD_STATUS, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_STATUS, 32'd0, 32'd0, 1'b0);
    // A periodic timer keeps running and clears its elapsed count.
    send_cmd(CMD_START, 32'd1, 32'd0, 1'b0);
    send_cmd(CMD_STATUS, 32'd1, 32'd0, 1'b0);
    // Reconfiguration: zero period, then an out-of-range slot with a zero
    // period (the slot check wins), then a good one.
    send_cmd(CMD_CONFIGURE, 32'd1, 32'd0, 1'b0);
    send_cmd(CMD_CONFIGURE, 32'hFFFF_FFFF, 32'd0, 1'b1);
    send_cmd(CMD_CONFIGURE, 32'd1, 32'h8000_0001, 1'b0);
    send_cmd(CMD_STATUS, 32'd1, 32'd0, 1'b0);
    send_cmd(CMD_STOP, 32'd1, 32'd0, 1'b0);
    send_cmd(CMD_STATUS, 32'd1, 32'd0, 1'b0);
    // Destroying twice: the second one hits a free slot.
    send_cmd(CMD_DESTROY, 32'd1, 32'd0, 1'b0);
    send_cmd(CMD_DESTROY, 32'd1, 32'd0, 1'b0);
    // Re-creating slot 1 must leave it stopped with zero elapsed time.
    send_cmd(CMD_CREATE, 32'd0, 32'd5, 1'b0);
    send_cmd(CMD_STATUS, 32'd1, 32'd0, 1'b0);
    // Undefined commands with the period and periodic fields busy, and the first slot
    // number past the table.
    send_cmd(CMD_UNUSED_LO, 32'd0, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_UNUSED_HI, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 1'b1);
    send_cmd(CMD_STATUS, 32'(TIMER_COUNT), 32'd0, 1'b0);

    // Random part. It opens by filling the table until creation fails, then
    // mixes all commands with phases that alternately favor create and destroy.
    repeat (TIMER_COUNT + 1)
      send_cmd(CMD_CREATE, $urandom(), $urandom_range(1, 32'hFFFF_FFFF),
               1'($urandom_range(0, 1)));
    for (int i = 0; i < RANDOM_ITEMS; i++)
      send_random_cmd(((i / 200) % 2) == 1);
    in_tvalid <= 1'b0;

    // Wait for every predicted response, then give the block time to show any
    // stray one. The watchdog covers a response that never comes.
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d command transactions and %0d checked responses.",
             cmds_seen, rsps_checked);
    $display("Outcomes: ok %0d, bad period %0d, table full %0d, bad slot %0d.",
             n_ok, n_bad_period, n_no_slot, n_bad_slot);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
